@@ src/tkpq_pkg.sv @@
// ----------------------------------------------------------------------------
// tkpq_pkg
// Shared types and constants of the two-key priority queue: entry layout,
// result status codes, controller states and the command group.
// ----------------------------------------------------------------------------
package tkpq_pkg;

  localparam int TKPQ_CAPACITY = 64;
  localparam int PRIO_W        = 8;
  localparam int TMT_W         = 16;
  localparam int TAG_W         = 16;
  localparam int OCC_W         = 7;

  typedef enum logic [1:0] {
    STAT_INSERTED = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_REMOVED  = 2'd2,
    STAT_EMPTY    = 2'd3
  } status_t;

  typedef enum logic {
    MODE_INSERT  = 1'b0,
    MODE_DEQUEUE = 1'b1
  } mode_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    logic [PRIO_W-1:0] prio;
    logic [TMT_W-1:0]  tmt;
    logic [TAG_W-1:0]  tag;
  } entry_t;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

endpackage

@@ src/tkpq_if.sv @@
// ----------------------------------------------------------------------------
// tkpq_if
// Request and result channels of the two-key priority queue.
// ----------------------------------------------------------------------------
interface tkpq_in_if;
  import tkpq_pkg::*;

  logic                valid;
  logic                ready;
  logic                mode;
  logic [PRIO_W-1:0]   priority_req;
  logic [TMT_W-1:0]    treatment;
  logic [TAG_W-1:0]    patient_id;

  modport source (output valid, mode, priority_req, treatment, patient_id, input ready);
  modport sink   (input valid, mode, priority_req, treatment, patient_id, output ready);
endinterface

interface tkpq_out_if;
  import tkpq_pkg::*;

  logic                valid;
  logic                ready;
  logic [1:0]          status;
  logic [PRIO_W-1:0]   out_priority;
  logic [TMT_W-1:0]    out_treatment;
  logic [TAG_W-1:0]    out_patient_id;
  logic [OCC_W-1:0]    occupancy;

  modport source (output valid, status, out_priority, out_treatment, out_patient_id,
                  occupancy, input ready);
  modport sink   (input valid, status, out_priority, out_treatment, out_patient_id,
                  occupancy, output ready);
endinterface

@@ src/tkpq_ctrl.sv @@
// ----------------------------------------------------------------------------
// tkpq_ctrl
// Controller: takes one request beat, runs one update step in the datapath,
// and holds the result beat valid until the receiver takes it.
// ----------------------------------------------------------------------------
module tkpq_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output tkpq_pkg::cmd_t cmd
);
  import tkpq_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   slot_free;

  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid && slot_free) state_nxt = S_EXEC;
      end
      S_EXEC: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd      = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = slot_free;
        cmd.load = in_valid && slot_free;
      end
      S_EXEC: cmd.exec = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.exec) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ src/tkpq_datapath.sv @@
// ----------------------------------------------------------------------------
// tkpq_datapath
// Row of sorted entry cells. Each cell compares the request keys with its own
// and decides locally whether to hold, take the new entry or take a neighbor.
// ----------------------------------------------------------------------------
module tkpq_datapath #(
  parameter int CAPACITY = tkpq_pkg::TKPQ_CAPACITY
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  tkpq_pkg::cmd_t              cmd,
  input  logic                        in_mode,
  input  logic [tkpq_pkg::PRIO_W-1:0] in_priority_req,
  input  logic [tkpq_pkg::TMT_W-1:0]  in_treatment,
  input  logic [tkpq_pkg::TAG_W-1:0]  in_patient_id,
  output logic [1:0]                  out_status,
  output logic [tkpq_pkg::PRIO_W-1:0] out_priority,
  output logic [tkpq_pkg::TMT_W-1:0]  out_treatment,
  output logic [tkpq_pkg::TAG_W-1:0]  out_patient_id,
  output logic [tkpq_pkg::OCC_W-1:0]  out_occupancy
);
  import tkpq_pkg::*;

  localparam int CW = $clog2(CAPACITY + 1);

  logic              mode_r;
  entry_t            req_r;
  entry_t            cell_r   [CAPACITY];
  entry_t            cell_nxt [CAPACITY];
  logic [CAPACITY-1:0] valid_r, valid_nxt;
  logic [CAPACITY-1:0] here;
  logic [CW-1:0]     count_r, count_nxt;
  logic              full, empty, do_ins, do_deq;

  status_t           status_r, status_nxt;
  entry_t            res_r, res_nxt;

  assign full   = valid_r[CAPACITY-1];
  assign empty  = !valid_r[0];
  assign do_ins = cmd.exec && (mode_r == MODE_INSERT) && !full;
  assign do_deq = cmd.exec && (mode_r == MODE_DEQUEUE) && !empty;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode_r   <= in_mode;
      req_r    <= '{prio: in_priority_req, tmt: in_treatment, tag: in_patient_id};
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    assign here[i] = !valid_r[i] ||
                     (req_r.prio < cell_r[i].prio) ||
                     ((req_r.prio == cell_r[i].prio) && (req_r.tmt <= cell_r[i].tmt));

    always_comb begin
      cell_nxt[i] = cell_r[i];
      if (do_ins) begin
        if (i == 0) begin
          if (here[i]) cell_nxt[i] = req_r;
        end else begin
          if (here[i] && !here[(i == 0) ? 0 : i-1]) cell_nxt[i] = req_r;
          else if (here[i]) cell_nxt[i] = cell_r[(i == 0) ? 0 : i-1];
        end
      end else if (do_deq && (i < CAPACITY-1)) begin
        cell_nxt[i] = cell_r[(i < CAPACITY-1) ? i+1 : i];
      end
    end

    always_ff @(posedge clk) begin
      cell_r[i] <= cell_nxt[i];
    end
  end

  always_comb begin
    valid_nxt = valid_r;
    count_nxt = count_r;
    if (do_ins) begin
      valid_nxt = {valid_r[CAPACITY-2:0], 1'b1};
      count_nxt = count_r + CW'(1);
    end else if (do_deq) begin
      valid_nxt = {1'b0, valid_r[CAPACITY-1:1]};
      count_nxt = count_r - CW'(1);
    end
  end

  always_comb begin
    res_nxt    = '0;
    status_nxt = STAT_INSERTED;
    if (mode_r == MODE_INSERT) begin
      status_nxt = full ? STAT_FULL : STAT_INSERTED;
    end else if (empty) begin
      status_nxt = STAT_EMPTY;
    end else begin
      status_nxt = STAT_REMOVED;
      res_nxt    = cell_r[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      count_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r      <= status_nxt;
      res_r         <= res_nxt;
      out_occupancy <= OCC_W'(count_nxt);
    end
  end

  assign out_status     = status_r;
  assign out_priority   = res_r.prio;
  assign out_treatment  = res_r.tmt;
  assign out_patient_id = res_r.tag;

endmodule

@@ src/two_key_priority_queue.sv @@
// ----------------------------------------------------------------------------
// two_key_priority_queue
// Bounded queue kept sorted by priority, then treatment time.
// ----------------------------------------------------------------------------
// Request beats on in_bus: mode 0 inserts {priority_req, treatment,
// patient_id}, mode 1 removes the head. A new entry goes ahead of held
// entries with equal keys. Every request gives one result beat on out_bus:
// status (inserted, full, removed, empty), the removed entry or zeros, and
// the occupancy after the step (low 7 bits of the count).
// Timing: a request is taken, the update runs in the next cycle, and the result
// is valid the cycle after that. The row of cells compares and shifts all
// entries in a single update step, and no new request is taken during it.
// The next request is taken once the update is done and the result register
// is free or being emptied; while the receiver stalls, one result is held and
// in_bus.ready drops until it is taken.
// Reset (rst_n low, synchronous) empties the queue and drops any pending
// result. Entry contents need no reset.
// ----------------------------------------------------------------------------
module two_key_priority_queue #(
  parameter int CAPACITY = tkpq_pkg::TKPQ_CAPACITY
) (
  input  logic              clk,
  input  logic              rst_n,
  tkpq_in_if.sink           in_bus,
  tkpq_out_if.source        out_bus
);
  import tkpq_pkg::*;

  cmd_t cmd;

  tkpq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .cmd       (cmd)
  );

  tkpq_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_mode         (in_bus.mode),
    .in_priority_req (in_bus.priority_req),
    .in_treatment    (in_bus.treatment),
    .in_patient_id   (in_bus.patient_id),
    .out_status      (out_bus.status),
    .out_priority    (out_bus.out_priority),
    .out_treatment   (out_bus.out_treatment),
    .out_patient_id  (out_bus.out_patient_id),
    .out_occupancy   (out_bus.occupancy)
  );

  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_bus.valid && in_bus.ready) |=> cmd.exec)
    else $error("accepted request not executed");

  a_exec_spaced: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> !cmd.exec)
    else $error("back-to-back update steps");

  a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_bus.valid) |-> $past(cmd.exec))
    else $error("result valid without update step");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |-> (!out_bus.valid || $past(out_bus.ready)))
    else $error("pending result overwritten");

endmodule

@@ test/tb_two_key_priority_queue.sv @@
// ----------------------------------------------------------------------------
// tb_two_key_priority_queue
// Self-checking bench for the two-key priority queue. A short directed run
// covers empty dequeue, key extremes and ties. Random segments then swing the
// queue between empty and full, with narrow key ranges to force ties. A
// sorted-list model predicts every result beat, and the monitor compares the
// beats field by field in order. Sender and receiver stalls change by phase.
// ----------------------------------------------------------------------------
module tb_two_key_priority_queue;
  timeunit 1ns;
  timeprecision 1ps;
  import tkpq_pkg::*;

  localparam int RANDOM_ITEMS = 1950;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 8;

  typedef struct packed {
    mode_t  mode;
    entry_t ent;
  } request_t;

  typedef struct packed {
    status_t          status;
    entry_t           ent;
    logic [OCC_W-1:0] occupancy;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_taken = 1'b0;

  tkpq_in_if  in_bus();
  tkpq_out_if out_bus();

  two_key_priority_queue dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_bus (in_bus),
    .out_bus(out_bus)
  );

  request_t    pending_requests[$];
  entry_t      held_entries[$];
  result_t     expected_results[$];
  int unsigned total_requests = 0;
  int unsigned accepted_requests = 0;
  int unsigned stall_cycles = 0;
  int unsigned error_count = 0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void add_request(mode_t m, logic [PRIO_W-1:0] p,
                                      logic [TMT_W-1:0] t, logic [TAG_W-1:0] g);
    request_t r;
    r.mode     = m;
    r.ent.prio = p;
    r.ent.tmt  = t;
    r.ent.tag  = g;
    pending_requests.insert(pending_requests.size(), r);
  endfunction

  // Sorted list: ascending priority, then treatment; new entry ahead of ties.
  function automatic result_t serve_request(request_t r);
    result_t res;
    int      pos;
    res = '0;
    if (r.mode == MODE_INSERT) begin
      if (held_entries.size() >= TKPQ_CAPACITY) begin
        res.status = STAT_FULL;
      end else begin
        pos = held_entries.size();
        for (int i = 0; i < held_entries.size(); i++) begin
          if (r.ent.prio < held_entries[i].prio ||
              (r.ent.prio == held_entries[i].prio && r.ent.tmt <= held_entries[i].tmt)) begin
            pos = i;
            break;
          end
        end
        held_entries.insert(pos, r.ent);
        res.status = STAT_INSERTED;
      end
    end else begin
      if (held_entries.size() == 0) begin
        res.status = STAT_EMPTY;
      end else begin
        res.ent    = held_entries.pop_front();
        res.status = STAT_REMOVED;
      end
    end
    res.occupancy = OCC_W'(held_entries.size());
    return res;
  endfunction

  task automatic check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, actual %0d", name, want, got);
      error_count++;
    end
  endtask

  // Driver: present a new beat once the previous one is taken.
  always @(negedge clk) begin
    int unsigned idle_in;
    int unsigned idle_out;
    request_t    beat;
    if (rst_n) begin
      if (accepted_requests < total_requests / 3) begin
        idle_in  = 17;
        idle_out = 55;
      end else if (accepted_requests < 2 * total_requests / 3) begin
        idle_in  = 55;
        idle_out = 17;
      end else begin
        idle_in  = 0;
        idle_out = 0;
      end
      out_bus.ready <= ($urandom_range(99) >= idle_out);
      if (!in_bus.valid || in_taken) begin
        if (pending_requests.size() != 0 && $urandom_range(99) >= idle_in) begin
          beat = pending_requests.pop_front();
          in_bus.valid        <= 1'b1;
          in_bus.mode         <= beat.mode;
          in_bus.priority_req <= beat.ent.prio;
          in_bus.treatment    <= beat.ent.tmt;
          in_bus.patient_id   <= beat.ent.tag;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: predict on each request beat, check each result beat.
  always @(posedge clk) begin
    request_t req;
    result_t  want;
    if (!rst_n) begin
      in_taken <= 1'b0;
    end else begin
      in_taken <= in_bus.valid && in_bus.ready;
      if (in_bus.valid && in_bus.ready) begin
        req.mode     = mode_t'(in_bus.mode);
        req.ent.prio = in_bus.priority_req;
        req.ent.tmt  = in_bus.treatment;
        req.ent.tag  = in_bus.patient_id;
        expected_results.insert(expected_results.size(), serve_request(req));
        accepted_requests++;
      end
      if (out_bus.valid && out_bus.ready) begin
        if (expected_results.size() == 0) begin
          $error("result beat with no request outstanding: status %0d", out_bus.status);
          error_count++;
        end else begin
          want = expected_results.pop_front();
          check_field("status", 32'(want.status), 32'(out_bus.status));
          check_field("out_priority", 32'(want.ent.prio), 32'(out_bus.out_priority));
          check_field("out_treatment", 32'(want.ent.tmt), 32'(out_bus.out_treatment));
          check_field("out_patient_id", 32'(want.ent.tag), 32'(out_bus.out_patient_id));
          check_field("occupancy", 32'(want.occupancy), 32'(out_bus.occupancy));
        end
      end
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles + 1 >= STALL_LIMIT) begin
        $display("tb_two_key_priority_queue: FAIL");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned produced;
    int unsigned seg_len;
    int unsigned insert_pct;
    bit          narrow_keys;
    mode_t       m;
    in_bus.valid        = 1'b0;
    in_bus.mode         = MODE_INSERT;
    in_bus.priority_req = '0;
    in_bus.treatment    = '0;
    in_bus.patient_id   = '0;
    out_bus.ready       = 1'b0;

    add_request(MODE_DEQUEUE, 8'hFF, 16'hFFFF, 16'hFFFF);
    add_request(MODE_INSERT, 8'hFF, 16'hFFFF, 16'hFFFF);
    add_request(MODE_INSERT, 8'h00, 16'h0000, 16'h0000);
    add_request(MODE_INSERT, 8'h00, 16'hFFFF, 16'h1234);
    add_request(MODE_INSERT, 8'hFF, 16'h0000, 16'hA5A5);
    add_request(MODE_INSERT, 8'h80, 16'h8000, 16'h0001);
    add_request(MODE_INSERT, 8'h80, 16'h8000, 16'h0002);
    add_request(MODE_INSERT, 8'h80, 16'h8000, 16'h0003);
    add_request(MODE_INSERT, 8'h80, 16'h7FFF, 16'h0004);
    add_request(MODE_INSERT, 8'h7F, 16'hFFFF, 16'h5A5A);
    // drain all nine, then one more on the empty queue
    for (int k = 0; k < 10; k++) begin
      add_request(MODE_DEQUEUE, PRIO_W'($urandom), TMT_W'($urandom), TAG_W'($urandom));
    end

    // segments biased to fill, churn or drain; the first one fills to the brim
    produced = 0;
    while (produced < RANDOM_ITEMS) begin
      if (produced == 0) begin
        seg_len    = 150;
        insert_pct = 95;
      end else begin
        seg_len = $urandom_range(160, 40);
        case ($urandom_range(2))
          0:       insert_pct = 92;
          1:       insert_pct = 50;
          default: insert_pct = 10;
        endcase
      end
      if (seg_len > RANDOM_ITEMS - produced) seg_len = RANDOM_ITEMS - produced;
      narrow_keys = ($urandom_range(3) == 0);
      for (int k = 0; k < seg_len; k++) begin
        m = ($urandom_range(99) < insert_pct) ? MODE_INSERT : MODE_DEQUEUE;
        if (narrow_keys) begin
          add_request(m, PRIO_W'($urandom_range(3)), TMT_W'($urandom_range(3)),
                      TAG_W'($urandom));
        end else begin
          add_request(m, PRIO_W'($urandom), TMT_W'($urandom), TAG_W'($urandom));
        end
      end
      produced += seg_len;
    end
    total_requests = pending_requests.size();

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (accepted_requests < total_requests || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("tb_two_key_priority_queue: PASS");
    end else begin
      $display("tb_two_key_priority_queue: FAIL");
    end
    $finish;
  end

endmodule
